// ===== src/particle_drag_integrator_assert.svh =====
// Assertion macros for the checker file.
`ifndef PARTICLE_DRAG_INTEGRATOR_ASSERT_SVH
`define PARTICLE_DRAG_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PDI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PDI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/pdi_pkg.sv =====
// ----------------------------------------------------------------------------
// pdi_pkg
// Types, constants and helpers for the particle drag integrator.
// ----------------------------------------------------------------------------
package pdi_pkg;

    localparam logic       CFG_ENABLE     = 1'b0;
    localparam logic       CFG_TIME_SCALE = 1'b1;

    localparam logic       KIND_FRAME     = 1'b0;
    localparam logic       KIND_PARTICLE  = 1'b1;

    localparam logic [20:0] CLOCK_MAX     = 21'h100000;
    localparam logic [3:0]  IMAGE_MAX     = 4'd15;
    localparam logic signed [63:0] GRAVITY_Y = -64'sd13107;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] mag;
        logic [15:0]      damp;
        logic [31:0]      life;
        logic [23:0]      loss;
        logic             alive;
        logic [3:0]       img;
        logic [23:0]      fs;
    } item_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== src/pdi_sqrt.sv =====
// ----------------------------------------------------------------------------
// pdi_sqrt
// Pipelined integer square root, one result bit per stage, item side data.
// ----------------------------------------------------------------------------
module pdi_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  pdi_pkg::item_t in_item,
    input  logic [63:0]    radicand,
    output logic           out_valid,
    output pdi_pkg::item_t out_item,
    output logic [31:0]    root
);
    import pdi_pkg::*;

    localparam int Steps = 32;

    logic        valid_reg [Steps];
    item_t       item_reg  [Steps];
    logic [63:0] rem_reg   [Steps];
    logic [31:0] root_reg  [Steps];

    genvar k;
    generate
        for (k = 0; k < Steps; k++) begin : g_stage
            localparam int B = Steps - 1 - k;
            logic        v_in;
            item_t       it_in;
            logic [63:0] rem_in;
            logic [31:0] root_in;
            logic [65:0] trial;
            logic        ge;
            logic [63:0] rem_next;
            logic [31:0] root_next;

            if (k == 0) begin : g_first
                assign v_in    = in_valid;
                assign it_in   = in_item;
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else begin : g_rest
                assign v_in    = valid_reg[k-1];
                assign it_in   = item_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // trial = (2*root + 2^B) * 2^B, root holding only bits above B
            always_comb
            begin
                trial     = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
                ge        = {2'b00, rem_in} >= trial;
                rem_next  = ge ? rem_in - trial[63:0] : rem_in;
                root_next = ge ? (root_in | (32'd1 << B)) : root_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (adv)
                    valid_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    item_reg[k] <= it_in;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Steps-1];
    assign out_item  = item_reg[Steps-1];
    assign root      = root_reg[Steps-1];

endmodule

// ===== src/particle_drag_integrator.sv =====
// ----------------------------------------------------------------------------
// particle_drag_integrator
// One semi-implicit Euler step with quadratic drag per particle item, Q16.16.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not held. A particle item's
// result passes through the capture register, squaring and summing, the
// bit-per-stage square root of |v|^2, the drag products, acceleration,
// the velocity and position updates, and the output register. A frame item
// updates the step and animation clock at the edge that accepts it and gives
// no result; particles accepted later use the new values. When the output is
// held the whole pipeline holds, so in_ready is high whenever out_ready is
// high or the output register holds no result.
module particle_drag_integrator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [15:0]         delta_time,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic [15:0]         damp,
    input  logic signed [31:0]  life,
    input  logic [15:0]         fade,
    input  logic                alive,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  new_pos_x,
    output logic signed [31:0]  new_pos_y,
    output logic signed [31:0]  new_pos_z,
    output logic signed [31:0]  new_vel_x,
    output logic signed [31:0]  new_vel_y,
    output logic signed [31:0]  new_vel_z,
    output logic signed [31:0]  new_life,
    output logic                still_alive,
    output logic [3:0]          image_index,
    output logic                image_updated
);
    import pdi_pkg::*;

    logic        enable_reg;
    logic [23:0] time_scale_reg;
    logic [23:0] fs_reg;
    logic [20:0] clock_reg;

    logic adv;
    logic acc_in;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign acc_in   = in_valid && in_ready && enable_reg;

    // ---------------- config and frame state ----------------
    logic [39:0] fs_prod;
    logic [21:0] clock_sum;
    logic [23:0] fs_next;
    logic [20:0] clock_next;

    always_comb
    begin
        fs_prod    = {16'd0, time_scale_reg} * {24'd0, delta_time};
        fs_next    = fs_prod[39:16];
        clock_sum  = {1'b0, clock_reg} + {2'b00, delta_time, 4'd0};
        clock_next = (clock_sum > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : clock_sum[20:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            time_scale_reg <= '0;
            fs_reg         <= '0;
            clock_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:     enable_reg     <= cfg_data[0];
                    CFG_TIME_SCALE: time_scale_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (acc_in && kind == KIND_FRAME)
            begin
                fs_reg    <= fs_next;
                clock_reg <= clock_next;
            end
        end
    end

    // ---------------- P0: capture ----------------
    item_t       item0_next;
    logic [39:0] loss_prod;
    logic [2:0][31:0] vin;
    logic [2:0][31:0] pin;

    always_comb
    begin
        vin = {vel_z, vel_y, vel_x};
        pin = {pos_z, pos_y, pos_x};
        loss_prod = {24'd0, fade} * {16'd0, fs_reg};
        item0_next.pos   = pin;
        item0_next.vel   = vin;
        for (int i = 0; i < 3; i++)
            item0_next.mag[i] = vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
        item0_next.damp  = damp;
        item0_next.life  = life;
        item0_next.loss  = loss_prod[39:16];
        item0_next.alive = alive;
        item0_next.img   = clock_reg[20] ? IMAGE_MAX : clock_reg[19:16];
        item0_next.fs    = fs_reg;
    end

    logic  v0_reg, v1_reg, v2_reg;
    item_t item0_reg, item1_reg, item2_reg;
    logic [2:0][63:0] sq_reg;
    logic [63:0] sum_reg;

    // ---------------- P1 squares, P2 sum ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= acc_in && kind == KIND_PARTICLE;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item0_reg <= item0_next;
            item1_reg <= item0_reg;
            item2_reg <= item1_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= {32'd0, item0_reg.mag[i]} * {32'd0, item0_reg.mag[i]};
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // ---------------- square root ----------------
    logic        sv;
    item_t       sitem;
    logic [31:0] speed;

    pdi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_item   (item2_reg),
        .radicand  (sum_reg),
        .out_valid (sv),
        .out_item  (sitem),
        .root      (speed)
    );

    // ---------------- drag and integration ----------------
    logic  vd_reg [1:7];
    item_t itd_reg [1:7];
    logic [2:0][63:0] prod_reg;
    logic [2:0][47:0] hi_reg;
    logic [2:0][47:0] lo_reg;
    logic [2:0][31:0] acc_reg;
    logic [31:0]      lifesub_reg;
    logic [2:0][40:0] dv_reg;
    logic [2:0][31:0] nvel_reg;
    logic [2:0][40:0] dp_reg;
    logic [2:0][31:0] npos_reg;

    logic [2:0][31:0] acc_next;
    logic [2:0][40:0] dv_next;
    logic [2:0][31:0] nvel_next;
    logic [2:0][40:0] dp_next;
    logic [2:0][31:0] npos_next;
    logic [31:0]      lifesub_next;

    always_comb
    begin
        logic [48:0]        msum;
        logic signed [63:0] g;
        logic signed [63:0] m;
        logic signed [56:0] p;
        for (int i = 0; i < 3; i++)
        begin
            // drag against the sign of v
            msum = {1'b0, hi_reg[i]} + {33'd0, lo_reg[i][47:32]};
            m    = $signed({23'd0, msum[48:8]});
            g    = (i == 1) ? GRAVITY_Y : 64'sd0;
            acc_next[i] = itd_reg[2].vel[i][31] ? sat32(g + m) : sat32(g - m);

            p = $signed(acc_reg[i]) * $signed({1'b0, itd_reg[3].fs});
            dv_next[i] = p[56:16];
            nvel_next[i] = sat32($signed({{23{dv_reg[i][40]}}, dv_reg[i]})
                                 + $signed({{32{itd_reg[4].vel[i][31]}}, itd_reg[4].vel[i]}));

            p = $signed(nvel_reg[i]) * $signed({1'b0, itd_reg[5].fs});
            dp_next[i] = p[56:16];
            npos_next[i] = sat32($signed({{23{dp_reg[i][40]}}, dp_reg[i]})
                                 + $signed({{32{itd_reg[6].pos[i][31]}}, itd_reg[6].pos[i]}));
        end
        lifesub_next = sat32($signed({{32{itd_reg[3].life[31]}}, itd_reg[3].life})
                             - $signed({40'd0, itd_reg[3].loss}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 7; s++)
                vd_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg[1] <= sv;
            for (int s = 2; s <= 7; s++)
                vd_reg[s] <= vd_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itd_reg[1] <= sitem;
            for (int s = 2; s <= 7; s++)
                itd_reg[s] <= itd_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= {32'd0, sitem.mag[i]} * {32'd0, speed};
                hi_reg[i]   <= {16'd0, prod_reg[i][63:32]} * {32'd0, itd_reg[1].damp};
                lo_reg[i]   <= {16'd0, prod_reg[i][31:0]} * {32'd0, itd_reg[1].damp};
            end
            acc_reg     <= acc_next;
            lifesub_reg <= lifesub_next;
            dv_reg      <= dv_next;
            nvel_reg    <= nvel_next;
            dp_reg      <= dp_next;
            npos_reg    <= npos_next;
        end
    end

    // ---------------- output register ----------------
    logic        out_valid_reg;
    logic [2:0][31:0] opos_reg;
    logic [2:0][31:0] ovel_reg;
    logic [31:0] olife_reg;
    logic        olive_reg;
    logic [3:0]  oimg_reg;

    logic        live0;
    logic        live_next;
    logic [31:0] life_next;
    logic [2:0][31:0] nvel_d_reg [1:2];
    logic [31:0] lifesub_d_reg [1:3];

    // new velocity and life difference wait for the position stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nvel_d_reg[1]    <= nvel_reg;
            nvel_d_reg[2]    <= nvel_d_reg[1];
            lifesub_d_reg[1] <= lifesub_reg;
            for (int s = 2; s <= 3; s++)
                lifesub_d_reg[s] <= lifesub_d_reg[s-1];
        end
    end

    always_comb
    begin
        live0     = itd_reg[7].alive && !npos_reg[1][31];
        live_next = live0 && !lifesub_d_reg[3][31] && (lifesub_d_reg[3] != 32'd0);
        life_next = live0 ? lifesub_d_reg[3] : itd_reg[7].life;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vd_reg[7];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            opos_reg  <= npos_reg;
            ovel_reg  <= nvel_d_reg[2];
            olife_reg <= life_next;
            olive_reg <= live_next;
            oimg_reg  <= live_next ? itd_reg[7].img : 4'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_pos_x     = opos_reg[0];
    assign new_pos_y     = opos_reg[1];
    assign new_pos_z     = opos_reg[2];
    assign new_vel_x     = ovel_reg[0];
    assign new_vel_y     = ovel_reg[1];
    assign new_vel_z     = ovel_reg[2];
    assign new_life      = olife_reg;
    assign still_alive   = olive_reg;
    assign image_index   = oimg_reg;
    assign image_updated = olive_reg;

endmodule

// ===== src/pdi_checker.sv =====
// ----------------------------------------------------------------------------
// pdi_checker
// Port-level assertions for the particle drag integrator.
// ----------------------------------------------------------------------------
`include "particle_drag_integrator_assert.svh"

module pdi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [31:0] new_pos_x,
    input logic              still_alive,
    input logic [3:0]        image_index,
    input logic              image_updated
);

    // a held result stays valid and its x position stays put
    `PDI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_pos_x))

    // a held result stalls the input side
    `PDI_ASSERT_NOW(a_backpressure, out_valid && !out_ready, !in_ready)

    // image flag tracks liveness
    `PDI_ASSERT_NOW(a_img_flag, out_valid, image_updated == still_alive)

    // dead particles carry a zero index
    `PDI_ASSERT_NOW(a_img_zero, out_valid && !image_updated, image_index == 4'd0)

endmodule

bind particle_drag_integrator pdi_checker u_pdi_checker (.*);
